>>> rtl/core/gfs_pkg.sv
package gfs_pkg;

    localparam int unsigned PayloadBytes = 18;
    localparam int unsigned FrameBytes   = 24;
    localparam int unsigned PayloadWidth = PayloadBytes * 8;

    localparam logic [7:0] HdrDollar = 8'h24;
    localparam logic [7:0] HdrM      = 8'h4D;
    localparam logic [7:0] HdrLt     = 8'h3C;
    localparam logic [7:0] LenByte   = 8'(PayloadBytes);
    localparam logic [7:0] CmdReset  = 8'd201;

    localparam logic [4:0] PosDollar = 5'd0;
    localparam logic [4:0] PosM      = 5'd1;
    localparam logic [4:0] PosLt     = 5'd2;
    localparam logic [4:0] PosLen    = 5'd3;
    localparam logic [4:0] PosCmd    = 5'd4;
    localparam logic [4:0] PosFirstP = 5'd5;
    localparam logic [4:0] PosLastP  = 5'd22;
    localparam logic [4:0] PosCsum   = 5'(FrameBytes - 1);

    typedef struct packed {
        logic [PayloadWidth-1:0] payload;
    } t_item;

endpackage

>>> rtl/core/gfs_front.sv
module gfs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_fix_kind,
    input  logic [7:0]           i_satellite_count,
    input  logic signed [30:0]   i_latitude,
    input  logic signed [31:0]   i_longitude,
    input  logic signed [15:0]   i_altitude,
    input  logic [15:0]          i_ground_speed,
    input  logic [15:0]          i_course,
    input  logic [15:0]          i_dilution,
    output logic                 o_valid,
    output gfs_pkg::t_item       o_item,
    input  logic                 i_ready
);
    import gfs_pkg::*;

    t_item       r_q [2];
    logic        r_wptr, n_wptr;
    logic        r_rptr, n_rptr;
    logic [1:0]  r_count, n_count;
    logic        wr, rd;
    t_item       packed_item;

    // little-endian payload, latitude sign extended to 32 bits
    assign packed_item.payload = {i_dilution, i_course, i_ground_speed, i_altitude,
                                  i_longitude, i_latitude[30], i_latitude,
                                  i_satellite_count, i_fix_kind};

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rptr];
    assign wr      = push && !full;
    assign rd      = o_valid && i_ready;

    always_comb begin
        n_wptr  = wr ? ~r_wptr : r_wptr;
        n_rptr  = rd ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wptr] <= packed_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_count == $past(r_count) + 2'd1))
        else $error("push not counted");

endmodule

>>> rtl/core/gfs_back.sv
module gfs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_valid,
    input  gfs_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      o_frame_byte,
    output logic            o_is_last
);
    import gfs_pkg::*;

    logic [7:0]              r_cmd;
    logic                    r_busy;
    logic [4:0]              r_pos;
    logic [7:0]              r_xor;
    logic [PayloadWidth-1:0] r_pl;
    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic                    r_out_last;
    logic                    adv, at_end, take;
    logic [7:0]              n_byte;

    assign o_cfg_ready  = 1'b1;
    assign empty        = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_is_last    = r_out_last;

    assign adv     = r_busy && (!r_out_valid || pop);
    assign at_end  = (r_pos == PosCsum);
    assign o_ready = !r_busy || (adv && at_end);
    assign take    = i_valid && o_ready;

    always_comb begin
        priority if (r_pos == PosDollar) begin
            n_byte = HdrDollar;
        end else if (r_pos == PosM) begin
            n_byte = HdrM;
        end else if (r_pos == PosLt) begin
            n_byte = HdrLt;
        end else if (r_pos == PosLen) begin
            n_byte = LenByte;
        end else if (r_pos == PosCmd) begin
            n_byte = r_cmd;
        end else if (r_pos == PosCsum) begin
            n_byte = r_xor;
        end else begin
            n_byte = r_pl[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CmdReset;
            r_busy      <= 1'b0;
            r_pos       <= PosDollar;
            r_xor       <= 8'd0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cmd <= i_cfg_data;
            end
            if (take) begin
                r_busy <= 1'b1;
            end else if (adv && at_end) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_pos       <= at_end ? PosDollar : r_pos + 5'd1;
                r_out_valid <= 1'b1;
                r_out_last  <= at_end;
                if (r_pos == PosDollar) begin
                    r_xor <= 8'd0;
                end else if (r_pos >= PosLen && r_pos <= PosLastP) begin
                    r_xor <= r_xor ^ n_byte;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= n_byte;
        end
        if (take) begin
            r_pl <= i_item.payload;
        end else if (adv && r_pos >= PosFirstP && r_pos <= PosLastP) begin
            r_pl <= {8'd0, r_pl[PayloadWidth-1:8]};
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosCsum) else $error("byte position out of range");
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pos == PosDollar)) else $error("idle with frame in progress");
    a_start_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_pos == PosDollar) |=> (r_out_byte == HdrDollar && !r_out_last))
        else $error("frame did not start with header");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && at_end) |=> (r_out_last && r_out_valid))
        else $error("checksum byte not flagged last");

endmodule

>>> rtl/core/gps_fix_frame_serializer.sv
// gps fix frame serializer
// input queue side: present a fix on the i_* field ports with push high; a
// transaction completes on a clock edge with push high and full low. a
// two-entry queue holds accepted fixes, so full rises only when two fixes
// wait behind the frame being sent.
// result queue side: while empty is low, o_frame_byte/o_is_last hold the oldest
// byte; pop high with empty low takes it. each fix gives 24 bytes: '$' 'M' '<',
// length 18, command, 18 payload bytes little-endian, then the xor checksum
// flagged by o_is_last.
// before its first byte shows, a fix passes the queue and the payload register.
// throughput: one byte per cycle while pop keeps up, set by the single
// byte-wide result register; frames follow each other with no gap.
// a stalled receiver (pop low) holds the current byte; the serializer waits and
// the input queue keeps taking fixes until full.
// config: i_cfg_data is taken on i_cfg_valid (o_cfg_ready is always high);
// write it only while idle. reset (i_rst_n low, synchronous) empties both
// sides and sets the command to 201.
module gps_fix_frame_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_fix_kind,
    input  logic [7:0]          i_satellite_count,
    input  logic signed [30:0]  i_latitude,
    input  logic signed [31:0]  i_longitude,
    input  logic signed [15:0]  i_altitude,
    input  logic [15:0]         i_ground_speed,
    input  logic [15:0]         i_course,
    input  logic [15:0]         i_dilution,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          o_frame_byte,
    output logic                o_is_last
);
    import gfs_pkg::*;

    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    gfs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_fix_kind        (i_fix_kind),
        .i_satellite_count (i_satellite_count),
        .i_latitude        (i_latitude),
        .i_longitude       (i_longitude),
        .i_altitude        (i_altitude),
        .i_ground_speed    (i_ground_speed),
        .i_course          (i_course),
        .i_dilution        (i_dilution),
        .o_valid           (q_valid),
        .o_item            (q_item),
        .i_ready           (q_ready)
    );

    gfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_ready      (q_ready),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_is_last    (o_is_last)
    );

endmodule
